>>> src/linear_probe_region_map_unit_macros.svh
// Assertion macros for the region map unit.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef LINEAR_PROBE_REGION_MAP_UNIT_MACROS_SVH
`define LINEAR_PROBE_REGION_MAP_UNIT_MACROS_SVH

// same-cycle implication
`define LPRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lprm_pkg.sv
// Shared types and constants for the region map unit.
// No dependencies.
package lprm_pkg;

  localparam logic [63:0] GOLDEN_MIX = 64'h9e3779b97f4a7c15;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_STORE  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_RSVD   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_PRESENT  = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_CLEAR,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] addr;
    logic [47:0] len;
    logic [31:0] handle;
  } slot_t;

endpackage

>>> src/linear_probe_region_map_unit.sv
// Top level of the region map: open-addressing table with linear probing.
// Depends on lprm_pkg, lprm_home and linear_probe_region_map_unit_macros.svh.
//
//  channel   ports                                       handshake
//  request   in_req_type in_region_addr in_region_len    start & !busy
//            in_handle_in
//  result    out_status out_handle_out                   out_valid, one cycle
//
// Lookup/store: one read of the single table memory per probe. Depths that are
// not a power of two add the remainder loop in lprm_home.
// Clear: one memory entry per cycle.
// After reset every memory entry is cleared while busy is high.
// The result receiver cannot stall; out_valid is a single-cycle strobe.
`include "linear_probe_region_map_unit_macros.svh"

module linear_probe_region_map_unit
  import lprm_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int PROBE_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_region_addr,
  input  logic [47:0] in_region_len,
  input  logic [31:0] in_handle_in,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_handle_out
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PW    = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(TABLE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  state_t           state_r, state_nxt;
  req_t             req_in;
  req_t             req_r;
  logic             accept;
  logic [63:0]      addr_r;
  logic [47:0]      len_r;
  logic [31:0]      handle_r;
  logic [IDX_W-1:0] probe_idx_r;
  logic [PW-1:0]    p_r;
  logic [IDX_W-1:0] sweep_idx_r;
  logic             sweep_last;
  logic             p_last;

  slot_t            mem [TABLE_DEPTH];
  slot_t            rd_data_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_addr_q_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;

  logic             hash_go;
  logic             home_vld;
  logic [IDX_W-1:0] home;

  logic             key_match;
  logic             finish;
  status_t          fin_status;
  logic [31:0]      fin_handle;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [31:0]      out_handle_r;

  assign req_in     = req_t'(in_req_type);
  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign sweep_last = (sweep_idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign p_last     = (p_r == PW'(PROBE_LIMIT - 1));
  assign key_match  = (rd_data_r.addr == addr_r) && (rd_data_r.len == len_r);

  lprm_home #(
    .DEPTH (TABLE_DEPTH)
  ) u_home (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (hash_go),
    .addr     (in_region_addr),
    .len      (in_region_len),
    .home_vld (home_vld),
    .home     (home)
  );

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r   <= mem[rd_addr];
      rd_addr_q_r <= rd_addr;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (req_in)
            REQ_LOOKUP, REQ_STORE: state_nxt = S_HASH;
            REQ_CLEAR:             state_nxt = S_CLEAR;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_HASH: begin
        if (home_vld) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (!rd_data_r.valid || key_match || p_last) state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        if (sweep_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = probe_idx_r;
    wr_en      = 1'b0;
    wr_addr    = rd_addr_q_r;
    wr_data    = rd_data_r;
    hash_go    = 1'b0;
    finish     = 1'b0;
    fin_status = ST_MISS;
    fin_handle = '0;
    case (state_r)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = sweep_idx_r;
        wr_data = '0;
      end
      S_IDLE: begin
        if (accept) begin
          case (req_in)
            REQ_LOOKUP, REQ_STORE: hash_go = 1'b1;
            REQ_CLEAR:             hash_go = 1'b0;
            default:               finish  = 1'b1;
          endcase
        end
      end
      S_HASH: begin
        if (home_vld) begin
          rd_en   = 1'b1;
          rd_addr = home;
        end
      end
      S_PROBE: begin
        if (!rd_data_r.valid) begin
          finish = 1'b1;
          if (req_r == REQ_STORE) begin
            wr_en      = 1'b1;
            wr_data    = '{valid: 1'b1, addr: addr_r, len: len_r, handle: handle_r};
            fin_status = ST_INSERTED;
          end
        end else if (key_match) begin
          finish = 1'b1;
          if (req_r == REQ_STORE) begin
            fin_status = ST_PRESENT;
          end else begin
            fin_status = ST_HIT;
            fin_handle = rd_data_r.handle;
          end
        end else if (p_last) begin
          finish     = 1'b1;
          fin_status = (req_r == REQ_STORE) ? ST_FULL : ST_MISS;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_CLEAR, S_DRAIN: begin
        if (state_r == S_CLEAR) begin
          rd_en   = 1'b1;
          rd_addr = sweep_idx_r;
        end else begin
          finish     = 1'b1;
          fin_status = ST_CLEARED;
        end
        // drop entries whose handle is not null
        if (rd_vld_r && rd_data_r.valid && (rd_data_r.handle != '0)) begin
          wr_en         = 1'b1;
          wr_data.valid = 1'b0;
        end
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_idx_r <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= finish;
      if (accept) begin
        sweep_idx_r <= '0;
      end else if (state_r == S_INIT || state_r == S_CLEAR) begin
        sweep_idx_r <= sweep_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= req_in;
      addr_r   <= in_region_addr;
      len_r    <= in_region_len;
      handle_r <= in_handle_in;
    end
    if (state_r == S_HASH && home_vld) begin
      probe_idx_r <= next_slot(home);
      p_r         <= '0;
    end else if (state_r == S_PROBE && rd_en) begin
      probe_idx_r <= next_slot(probe_idx_r);
      p_r         <= p_r + 1'b1;
    end
    if (finish) begin
      out_status_r <= fin_status;
      out_handle_r <= fin_handle;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_handle_out = out_handle_r;

  `LPRM_ASSERT_IMP(a_rw_distinct, rd_en && wr_en, rd_addr != wr_addr, "read and write hit the same slot")
  `LPRM_ASSERT_IMP(a_idle_no_write, state_r == S_IDLE, !wr_en, "table written while idle")
  `LPRM_ASSERT_IMP(a_home_in_hash, home_vld, state_r == S_HASH, "home slot outside hash wait")
  `LPRM_ASSERT_NXT(a_result_cause, !busy && !start, !out_valid, "result without a request")

endmodule

>>> src/lprm_home.sv
// Home slot unit: two-stage golden-ratio mix, then reduction to the table depth.
// Power-of-two depth masks; other depths use a radix-4 remainder loop. Uses lprm_pkg.
module lprm_home
  import lprm_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic [63:0]              addr,
  input  logic [47:0]              len,
  output logic                     home_vld,
  output logic [$clog2(DEPTH)-1:0] home
);

  localparam int  IDX_W   = $clog2(DEPTH);
  localparam bit  IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);

  logic        s1_vld_r;
  logic        s2_vld_r;
  logic [63:0] x_r;
  logic [47:0] l_r;
  logic [63:0] x2_r;
  logic [63:0] part_r;
  logic [63:0] lc_r;
  logic [63:0] mix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= go;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r <= addr;
      l_r <= len;
    end
    if (s1_vld_r) begin
      x2_r   <= x_r;
      part_r <= (x_r << 6) + (x_r >> 2);
      lc_r   <= {16'b0, l_r} + GOLDEN_MIX;
    end
  end

  assign mix = x2_r ^ (part_r + lc_r);

  generate
    if (IS_POW2) begin : g_mask
      assign home_vld = s2_vld_r;
      assign home     = mix[IDX_W-1:0];
    end else begin : g_mod
      localparam int              STEPS = 32;
      localparam logic [IDX_W+1:0] D1   = (IDX_W+2)'(DEPTH);
      localparam logic [IDX_W+1:0] D2   = (IDX_W+2)'(2 * DEPTH);
      localparam logic [IDX_W+1:0] D3   = (IDX_W+2)'(3 * DEPTH);

      logic             run_r;
      logic [4:0]       cnt_r;
      logic [63:0]      mix_r;
      logic [IDX_W-1:0] rem_r;
      logic [IDX_W+1:0] v;
      logic [IDX_W-1:0] rem_nxt;

      assign v = {rem_r, mix_r[63:62]};

      always_comb begin
        if (v >= D3) begin
          rem_nxt = IDX_W'(v - D3);
        end else if (v >= D2) begin
          rem_nxt = IDX_W'(v - D2);
        end else if (v >= D1) begin
          rem_nxt = IDX_W'(v - D1);
        end else begin
          rem_nxt = IDX_W'(v);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          run_r <= 1'b0;
        end else if (s2_vld_r) begin
          run_r <= 1'b1;
        end else if (run_r && cnt_r == 5'(STEPS - 1)) begin
          run_r <= 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (s2_vld_r) begin
          mix_r <= mix;
          rem_r <= '0;
          cnt_r <= '0;
        end else if (run_r) begin
          mix_r <= mix_r << 2;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 5'd1;
        end
      end

      assign home_vld = run_r && (cnt_r == 5'(STEPS - 1));
      assign home     = rem_nxt;
    end
  endgenerate

endmodule
